[src/rpza_pkg.sv]
package rpza_pkg;

    localparam int PIX_W  = 15;
    localparam int ROW_W  = 60;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;
    localparam int RUN_W  = 6;
    localparam int BLK_W  = 21;

    localparam int MAX_BLOCKS_PER_SIDE = 1024;

    localparam logic [1:0] KIND_BLOCK   = 2'd0;
    localparam logic [1:0] KIND_BADOP   = 2'd1;
    localparam logic [1:0] KIND_PASTEND = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER, PH_OPCODE, PH_A_LO, PH_PEEK, PH_FILL_HI, PH_FILL_LO,
        PH_QA_HI, PH_QA_LO, PH_QB_HI, PH_QB_LO, PH_INDEX, PH_SIX_HI, PH_SIX_LO
    } t_phase;

    typedef enum logic [1:0] {
        CMD_BLOCK, CMD_SKIP, CMD_STATUS, CMD_START
    } t_cmd_op;

    // one command from front to back
    typedef struct packed {
        t_cmd_op          op;
        logic [1:0]       kind;
        logic [RUN_W-1:0] count;
        logic [ROW_W-1:0] row0;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
        logic [ROW_W-1:0] row3;
    } t_cmd;

    function automatic logic [4:0] blend5(input logic [4:0] a, input logic [4:0] b,
                                          input logic [4:0] wa, input logic [4:0] wb);
        logic [10:0] s;
        s = 11'(wa * a) + 11'(wb * b);
        return s[9:5];
    endfunction

    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [4:0] wa, input logic [4:0] wb);
        return {blend5(a[14:10], b[14:10], wa, wb), blend5(a[9:5], b[9:5], wa, wb),
                blend5(a[4:0], b[4:0], wa, wb)};
    endfunction

endpackage

[src/rpza_if.sv]
interface rpza_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       chunk_start;
    modport source (output valid, byte_in, chunk_start, input ready);
    modport sink   (input valid, byte_in, chunk_start, output ready);
endinterface

interface rpza_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  block_col;
    logic [9:0]  block_row;
    logic [59:0] pixels_row0;
    logic [59:0] pixels_row1;
    logic [59:0] pixels_row2;
    logic [59:0] pixels_row3;
    modport source (output valid, kind, block_col, block_row, pixels_row0, pixels_row1,
                    pixels_row2, pixels_row3, input ready);
    modport sink   (input valid, kind, block_col, block_row, pixels_row0, pixels_row1,
                    pixels_row2, pixels_row3, output ready);
endinterface

interface rpza_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/rpza_front.sv]
module rpza_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpza_in_if.sink       in_ch,
    output rpza_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import rpza_pkg::*;

    t_phase           r_phase, n_phase;
    logic [4:0]       r_cnt, n_cnt;
    logic [RUN_W-1:0] r_run, n_run;
    logic [PIX_W-1:0] r_ca, n_ca, r_cb, n_cb;
    logic [PIX_W-1:0] r_pal [4];
    logic [7:0]       r_ix [3];
    logic [7:0]       n_ix;
    logic             n_ix_we;
    logic             r_halt, n_halt;
    logic             n_pal_we;
    logic [PIX_W-1:0] r_six [16];
    logic             six_we;
    logic [3:0]       six_wa;
    logic [PIX_W-1:0] six_wd;
    logic             r_cv, emit;
    t_cmd             r_cmd, n_cmd;
    logic [7:0]       b;
    logic             fire;

    assign b = in_ch.byte_in;
    assign in_ch.ready = !r_cv || i_cmd_ready;
    assign fire = in_ch.valid && in_ch.ready;
    assign o_cmd = r_cmd;
    assign o_cmd_valid = r_cv;

    function automatic logic [ROW_W-1:0] qrow(input logic [7:0] ix,
                                              input logic [PIX_W-1:0] p [4]);
        return {p[ix[7:6]], p[ix[5:4]], p[ix[3:2]], p[ix[1:0]]};
    endfunction

    always_comb begin
        logic st;
        logic [PIX_W-1:0] full;
        n_phase = r_phase; n_cnt = r_cnt; n_run = r_run; n_ca = r_ca; n_cb = r_cb;
        n_halt = r_halt; n_pal_we = 1'b0; n_ix = b; n_ix_we = 1'b0;
        six_we = 1'b0; six_wa = r_cnt[3:0]; six_wd = {b[6:0], 8'h00};
        emit = 1'b0; n_cmd = r_cmd;
        n_cmd.kind = KIND_BLOCK;
        st = in_ch.chunk_start;
        if (st) begin
            n_phase = PH_HEADER; n_cnt = '0; n_run = '0; n_ca = '0; n_cb = '0;
            n_halt = 1'b0; emit = 1'b1; n_cmd.op = CMD_START;
        end
        full = {b[6:0], 8'h00};
        if (!(st ? 1'b0 : r_halt)) begin
            case (st ? PH_HEADER : r_phase)
                PH_HEADER: begin
                    if ((st ? 5'd0 : r_cnt) >= 5'd3) begin
                        n_cnt = '0; n_phase = PH_OPCODE;
                    end else begin
                        n_cnt = (st ? 5'd0 : r_cnt) + 5'd1;
                    end
                end
                PH_OPCODE: begin
                    n_run = {1'b0, b[4:0]} + 6'd1;
                    if (!b[7]) begin
                        n_ca = full; n_phase = PH_A_LO;
                    end else if (b[7:5] == 3'b100) begin
                        emit = 1'b1; n_cmd.op = CMD_SKIP;
                        n_cmd.count = {1'b0, b[4:0]} + 6'd1;
                    end else if (b[7:5] == 3'b101) begin
                        n_phase = PH_FILL_HI;
                    end else if (b[7:5] == 3'b110) begin
                        n_phase = PH_QA_HI;
                    end else begin
                        emit = 1'b1; n_cmd.op = CMD_STATUS; n_cmd.kind = KIND_BADOP;
                        n_halt = 1'b1;
                    end
                end
                PH_A_LO: begin
                    n_ca = r_ca | {7'd0, b}; n_phase = PH_PEEK;
                end
                PH_PEEK: begin
                    if (b[7]) begin
                        n_run = 6'd1; n_cb = full; n_phase = PH_QB_LO;
                    end else begin
                        six_we = 1'b1; six_wa = 4'd1; n_cnt = 5'd1; n_phase = PH_SIX_LO;
                    end
                end
                PH_FILL_HI: begin
                    n_ca = full; n_phase = PH_FILL_LO;
                end
                PH_FILL_LO: begin
                    n_ca = r_ca | {7'd0, b};
                    emit = 1'b1; n_cmd.op = CMD_BLOCK; n_cmd.count = r_run;
                    n_cmd.row0 = {4{n_ca}}; n_cmd.row1 = {4{n_ca}};
                    n_cmd.row2 = {4{n_ca}}; n_cmd.row3 = {4{n_ca}};
                    n_phase = PH_OPCODE;
                end
                PH_QA_HI: begin
                    n_ca = full; n_phase = PH_QA_LO;
                end
                PH_QA_LO: begin
                    n_ca = r_ca | {7'd0, b}; n_phase = PH_QB_HI;
                end
                PH_QB_HI: begin
                    n_cb = full; n_phase = PH_QB_LO;
                end
                PH_QB_LO: begin
                    n_cb = r_cb | {7'd0, b}; n_pal_we = 1'b1; n_cnt = '0;
                    n_phase = PH_INDEX;
                end
                PH_INDEX: begin
                    if (r_cnt < 5'd3) begin
                        n_ix_we = 1'b1; n_cnt = r_cnt + 5'd1;
                    end else begin
                        emit = 1'b1; n_cmd.op = CMD_BLOCK; n_cmd.count = 6'd1;
                        n_cmd.row0 = qrow(r_ix[0], r_pal); n_cmd.row1 = qrow(r_ix[1], r_pal);
                        n_cmd.row2 = qrow(r_ix[2], r_pal); n_cmd.row3 = qrow(b, r_pal);
                        n_cnt = '0;
                        n_run = (r_run > 6'd0) ? r_run - 6'd1 : r_run;
                        if (n_run == 6'd0) n_phase = PH_OPCODE;
                    end
                end
                PH_SIX_HI: begin
                    six_we = 1'b1; n_phase = PH_SIX_LO;
                end
                PH_SIX_LO: begin
                    six_we = 1'b1; six_wd = r_six[r_cnt[3:0]] | {7'd0, b};
                    if (r_cnt[3:0] != 4'd15) begin
                        n_cnt = r_cnt + 5'd1; n_phase = PH_SIX_HI;
                    end else begin
                        emit = 1'b1; n_cmd.op = CMD_BLOCK; n_cmd.count = 6'd1;
                        n_cmd.row0 = {r_six[0], r_six[1], r_six[2], r_six[3]};
                        n_cmd.row1 = {r_six[4], r_six[5], r_six[6], r_six[7]};
                        n_cmd.row2 = {r_six[8], r_six[9], r_six[10], r_six[11]};
                        n_cmd.row3 = {r_six[12], r_six[13], r_six[14], six_wd};
                        n_cnt = '0; n_phase = PH_OPCODE;
                    end
                end
                default: n_phase = PH_OPCODE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_cnt <= '0; r_run <= '0; r_ca <= '0; r_cb <= '0;
            r_halt <= 1'b0; r_cv <= 1'b0;
            r_pal <= '{default: '0}; r_ix <= '{default: '0};
        end else begin
            if (i_cmd_ready) r_cv <= 1'b0;
            if (fire) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_run <= n_run; r_ca <= n_ca;
                r_cb <= n_cb; r_halt <= n_halt;
                if (emit) r_cv <= 1'b1;
                if (in_ch.chunk_start) begin
                    r_pal <= '{default: '0}; r_ix <= '{default: '0};
                end
                if (n_ix_we) r_ix[r_cnt[1:0]] <= n_ix;
                if (n_pal_we) begin
                    r_pal[0] <= n_cb; r_pal[3] <= n_ca;
                    r_pal[1] <= blend(n_ca, n_cb, 5'd11, 5'd21);
                    r_pal[2] <= blend(n_ca, n_cb, 5'd21, 5'd11);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (emit) r_cmd <= n_cmd;
            if (in_ch.chunk_start || r_phase == PH_PEEK) r_six[0] <= n_ca;
            if (six_we) r_six[six_wa] <= six_wd;
        end
    end
endmodule

[src/rpza_queue.sv]
module rpza_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpza_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    output logic           o_ready,
    output rpza_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_ready
);
    import rpza_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_n;
    logic          wr, rd;

    assign o_ready = r_n != (AW+1)'(DEPTH);
    assign o_valid = r_n != '0;
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_n <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_n <= r_n + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule

[src/rpza_back.sv]
module rpza_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpza_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [10:0]    i_width,
    input  logic [10:0]    i_height,
    rpza_out_if.source     out_ch
);
    import rpza_pkg::*;
    localparam int SW = $clog2(MAX_BLOCKS_PER_SIDE + 1);

    logic [POS_W-1:0] r_col, r_row;
    logic [BLK_W-1:0] r_left;
    logic [RUN_W-1:0] r_done;
    logic             r_halt, r_ov;
    logic [SW-1:0]    ew, eh;
    logic             last, busy_ok, fin;

    assign ew = (i_width  > 11'(MAX_BLOCKS_PER_SIDE)) ? SW'(MAX_BLOCKS_PER_SIDE) : SW'(i_width);
    assign eh = (i_height > 11'(MAX_BLOCKS_PER_SIDE)) ? SW'(MAX_BLOCKS_PER_SIDE) : SW'(i_height);
    assign busy_ok = !r_ov || out_ch.ready;
    assign last = (r_done + 6'd1 >= i_cmd.count);
    // a step ends the command at run end, frame end, halt, or a one-shot command
    assign fin = (i_cmd.op == CMD_START) || (i_cmd.op == CMD_STATUS) || r_halt ||
                 r_left == '0 || last;
    assign o_ready = i_valid && busy_ok && fin;
    assign out_ch.valid = r_ov;

    always_ff @(posedge i_clk) begin
        logic [SW:0] nc;
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_left <= '0; r_done <= '0;
            r_halt <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (out_ch.ready) r_ov <= 1'b0;
            if (i_valid && busy_ok) begin
                r_done <= fin ? '0 : r_done + 6'd1;
                if (i_cmd.op == CMD_START) begin
                    r_col <= '0; r_row <= '0; r_halt <= 1'b0;
                    r_left <= BLK_W'(ew * eh);
                end else if (!r_halt) begin
                    if (i_cmd.op == CMD_STATUS) begin
                        r_halt <= 1'b1; r_ov <= 1'b1;
                        out_ch.kind <= i_cmd.kind;
                    end else if (r_left == '0) begin
                        r_halt <= 1'b1; r_ov <= 1'b1;
                        out_ch.kind <= KIND_PASTEND;
                    end else begin
                        if (i_cmd.op == CMD_BLOCK) begin
                            r_ov <= 1'b1;
                            out_ch.kind <= KIND_BLOCK;
                        end
                        nc = (SW+1)'(r_col) + 1'b1;
                        if (nc >= (SW+1)'(ew)) begin
                            r_col <= '0; r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= POS_W'(nc);
                        end
                        r_left <= r_left - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && busy_ok) begin
            if (!r_halt && i_cmd.op == CMD_BLOCK && r_left != '0) begin
                out_ch.block_col <= r_col; out_ch.block_row <= r_row;
                out_ch.pixels_row0 <= i_cmd.row0; out_ch.pixels_row1 <= i_cmd.row1;
                out_ch.pixels_row2 <= i_cmd.row2; out_ch.pixels_row3 <= i_cmd.row3;
            end else begin
                out_ch.block_col <= '0; out_ch.block_row <= '0;
                out_ch.pixels_row0 <= '0; out_ch.pixels_row1 <= '0;
                out_ch.pixels_row2 <= '0; out_ch.pixels_row3 <= '0;
            end
        end
    end
endmodule

[src/rpza_block_decoder.sv]
// channel  dir  beat
// in_ch    in   byte_in, chunk_start
// cfg_ch   in   index, data (width_blocks, height_blocks)
// out_ch   out  kind, block_col, block_row, pixels_row0..3
// One byte a cycle in the parser; a fill run emits one block a cycle in the
// back end while the output accepts beats; skips step likewise.
// Parser stalls only when the two-entry command queue is full.
// Reset is synchronous, active low; frame size resets to 16 x 16 blocks.
module rpza_block_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpza_in_if.sink   in_ch,
    rpza_cfg_if.sink  cfg_ch,
    rpza_out_if.source out_ch
);
    import rpza_pkg::*;

    logic [CFG_W-1:0] r_w, r_h;
    t_cmd f_cmd, q_cmd;
    logic f_v, f_r, q_v, q_r;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd16; r_h <= 11'd16;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_WIDTH:  r_w <= cfg_ch.data;
                REG_HEIGHT: r_h <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    rpza_front u_front (.i_clk, .i_rst_n, .in_ch, .o_cmd(f_cmd), .o_cmd_valid(f_v),
                        .i_cmd_ready(f_r));
    rpza_queue #(.DEPTH(2)) u_queue (.i_clk, .i_rst_n, .i_cmd(f_cmd), .i_valid(f_v),
                        .o_ready(f_r), .o_cmd(q_cmd), .o_valid(q_v), .i_ready(q_r));
    rpza_back u_back (.i_clk, .i_rst_n, .i_cmd(q_cmd),
                        .i_valid(q_v), .o_ready(q_r), .i_width(r_w), .i_height(r_h),
                        .out_ch);
endmodule

[src/rpza_checker.sv]
module rpza_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [9:0]  out_col,
    input logic [59:0] out_row0
);
    import rpza_pkg::*;

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_kind == KIND_BLOCK || out_kind == KIND_BADOP ||
                       out_kind == KIND_PASTEND)) else $error("bad kind");
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_kind != KIND_BLOCK |-> out_col == '0 && out_row0 == '0)
        else $error("status payload not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("stalled beat changed");
endmodule

bind rpza_block_decoder rpza_checker u_chk (.i_clk, .i_rst_n, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_kind(out_ch.kind), .out_col(out_ch.block_col),
    .out_row0(out_ch.pixels_row0));

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import rpza_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [59:0] r0;
        logic [59:0] r1;
        logic [59:0] r2;
        logic [59:0] r3;
    } t_block;

    localparam int MAX_SIDE   = 1024;
    localparam int IDLE_WAIT  = 100;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rpza_in_if  in_ch();
    rpza_cfg_if cfg_ch();
    rpza_out_if out_ch();

    rpza_block_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_block      pending_blocks[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          sent_bytes = 0;

    // decoder mirror
    logic [10:0] frame_w = 11'd16;
    logic [10:0] frame_h = 11'd16;
    t_phase      phase = PH_HEADER;
    int          byte_cnt = 0;
    int          run_left = 0;
    logic [14:0] col_a = '0;
    logic [14:0] col_b = '0;
    logic [14:0] pal[4];
    logic [7:0]  idx_rows[3];
    logic [14:0] six[16];
    int          cur_col = 0;
    int          cur_row = 0;
    int unsigned left_blocks = 0;
    bit          halted = 1'b0;

    function automatic int clamp_side(logic [10:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic logic [59:0] pack4(logic [14:0] p0, logic [14:0] p1,
                                          logic [14:0] p2, logic [14:0] p3);
        return {p0, p1, p2, p3};
    endfunction

    function automatic logic [14:0] mix(logic [14:0] a, logic [14:0] b, int wa, int wb);
        logic [14:0] res;
        int          ca;
        int          cb;
        res = '0;
        for (int s = 0; s < 15; s += 5) begin
            ca = (a >> s) & 31;
            cb = (b >> s) & 31;
            res |= 15'((((wa * ca + wb * cb) >> 5) & 31) << s);
        end
        return res;
    endfunction

    function automatic logic [59:0] quad_pixels(logic [7:0] ix);
        return pack4(pal[ix[7:6]], pal[ix[5:4]], pal[ix[3:2]], pal[ix[1:0]]);
    endfunction

    function automatic void push_status(logic [1:0] kind);
        t_block s;
        s = '0;
        s.kind = kind;
        pending_blocks.push_back(s);
        halted = 1'b1;
    endfunction

    function automatic void step_position();
        cur_col++;
        if (cur_col >= clamp_side(frame_w)) begin
            cur_col = 0;
            cur_row = (cur_row + 1) & 10'h3ff;
        end
        left_blocks--;
    endfunction

    function automatic bit emit_block(logic [59:0] r0, logic [59:0] r1,
                                      logic [59:0] r2, logic [59:0] r3);
        t_block blk;
        if (left_blocks == 0) begin
            push_status(KIND_PASTEND);
            return 1'b0;
        end
        blk = {KIND_BLOCK, 10'(cur_col), 10'(cur_row), r0, r1, r2, r3};
        pending_blocks.push_back(blk);
        step_position();
        return 1'b1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic start);
        logic [59:0] fill;
        int          k;
        if (start) begin
            phase = PH_HEADER;
            byte_cnt = 0;
            run_left = 0;
            col_a = '0;
            col_b = '0;
            foreach (pal[i]) pal[i] = '0;
            foreach (idx_rows[i]) idx_rows[i] = '0;
            cur_col = 0;
            cur_row = 0;
            left_blocks = clamp_side(frame_w) * clamp_side(frame_h);
            halted = 1'b0;
        end
        if (halted) return;
        case (phase)
            PH_HEADER: begin
                byte_cnt++;
                if (byte_cnt >= 4) begin
                    byte_cnt = 0;
                    phase = PH_OPCODE;
                end
            end
            PH_OPCODE: begin
                run_left = (b & 8'h1f) + 1;
                if (!b[7]) begin
                    col_a = {b[6:0], 8'h00};
                    phase = PH_A_LO;
                end else if (b[7:5] == 3'b100) begin
                    while (run_left > 0) begin
                        run_left--;
                        if (left_blocks == 0) begin
                            push_status(KIND_PASTEND);
                            break;
                        end
                        step_position();
                    end
                end else if (b[7:5] == 3'b101) begin
                    phase = PH_FILL_HI;
                end else if (b[7:5] == 3'b110) begin
                    phase = PH_QA_HI;
                end else begin
                    push_status(KIND_BADOP);
                end
            end
            PH_A_LO: begin
                col_a = col_a | b;
                phase = PH_PEEK;
            end
            PH_PEEK: begin
                if (b[7]) begin
                    run_left = 1;
                    col_b = {b[6:0], 8'h00};
                    phase = PH_QB_LO;
                end else begin
                    six[0] = col_a;
                    six[1] = {b[6:0], 8'h00};
                    byte_cnt = 1;
                    phase = PH_SIX_LO;
                end
            end
            PH_FILL_HI: begin
                col_a = {b[6:0], 8'h00};
                phase = PH_FILL_LO;
            end
            PH_FILL_LO: begin
                col_a = col_a | b;
                fill = pack4(col_a, col_a, col_a, col_a);
                while (run_left > 0) begin
                    run_left--;
                    if (!emit_block(fill, fill, fill, fill)) break;
                end
                phase = PH_OPCODE;
            end
            PH_QA_HI: begin
                col_a = {b[6:0], 8'h00};
                phase = PH_QA_LO;
            end
            PH_QA_LO: begin
                col_a = col_a | b;
                phase = PH_QB_HI;
            end
            PH_QB_HI: begin
                col_b = {b[6:0], 8'h00};
                phase = PH_QB_LO;
            end
            PH_QB_LO: begin
                col_b = col_b | b;
                pal[0] = col_b;
                pal[3] = col_a;
                pal[1] = mix(col_a, col_b, 11, 21);
                pal[2] = mix(col_a, col_b, 21, 11);
                byte_cnt = 0;
                phase = PH_INDEX;
            end
            PH_INDEX: begin
                if (byte_cnt < 3) begin
                    idx_rows[byte_cnt] = b;
                    byte_cnt++;
                end else begin
                    byte_cnt = 0;
                    if (run_left > 0) run_left--;
                    if (!(emit_block(quad_pixels(idx_rows[0]), quad_pixels(idx_rows[1]),
                                     quad_pixels(idx_rows[2]), quad_pixels(b))
                          && run_left > 0)) begin
                        run_left = 0;
                        phase = PH_OPCODE;
                    end
                end
            end
            PH_SIX_HI: begin
                six[byte_cnt & 15] = {b[6:0], 8'h00};
                phase = PH_SIX_LO;
            end
            PH_SIX_LO: begin
                k = byte_cnt & 15;
                six[k] = six[k] | b;
                if (k < 15) begin
                    byte_cnt = k + 1;
                    phase = PH_SIX_HI;
                end else begin
                    byte_cnt = 0;
                    void'(emit_block(pack4(six[0], six[1], six[2], six[3]),
                                     pack4(six[4], six[5], six[6], six[7]),
                                     pack4(six[8], six[9], six[10], six[11]),
                                     pack4(six[12], six[13], six[14], six[15])));
                    phase = PH_OPCODE;
                end
            end
            default: phase = PH_OPCODE;
        endcase
    endfunction

    // ---------------- drivers ----------------
    initial begin
        in_ch.valid = 1'b0;
        in_ch.byte_in = '0;
        in_ch.chunk_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_WIDTH;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    task automatic send_byte(logic [7:0] b, logic start = 1'b0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.byte_in <= b;
        in_ch.chunk_start <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_byte(b, start);
        sent_bytes++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [10:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == REG_WIDTH) frame_w = val;
        else frame_h = val;
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_header();
        send_byte(8'($urandom), 1'b1);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic send_color(logic [15:0] c);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
    endtask

    task automatic send_quad(int n);
        send_byte(8'hc0 | 8'(n));
        send_color(16'($urandom));
        send_color(16'($urandom));
        repeat (4 * (n + 1)) send_byte(8'($urandom));
    endtask

    task automatic send_short_quad();
        send_byte(8'($urandom) & 8'h7f);
        send_byte(8'($urandom));
        send_byte(8'($urandom) | 8'h80);
        send_byte(8'($urandom));
        repeat (4) send_byte(8'($urandom));
    endtask

    task automatic send_sixteen();
        send_byte(8'($urandom) & 8'h7f);
        send_byte(8'($urandom));
        send_byte(8'($urandom) & 8'h7f);
        repeat (29) send_byte(8'($urandom));
    endtask

    // ---------------- tests ----------------
    task automatic test_before_chunk();
        repeat (4) send_byte(8'($urandom));
        send_byte(8'ha0);
        send_color(16'h1234);
        send_byte(8'h55);
    endtask

    task automatic test_opcodes();
        set_frame(11'd3, 11'd2);
        send_header();
        send_byte(8'ha0);
        send_color(16'hffff);
        send_byte(8'h80);
        send_byte(8'hc0);
        send_color(16'h7fff);
        send_color(16'h0000);
        send_byte(8'h1b);
        send_byte(8'he4);
        send_byte(8'h00);
        send_byte(8'hff);
        send_short_quad();
        send_byte(8'ha5);
        send_color(16'h0421);
        send_byte(8'h00);
    endtask

    task automatic test_sixteen_and_badop();
        set_frame(11'd1, 11'd1);
        send_header();
        send_sixteen();
        send_header();
        send_byte(8'he0);
        send_byte(8'h80);
        send_header();
        send_byte(8'hc1);
        send_color(16'h1111);
        send_header();
        send_byte(8'hff);
    endtask

    task automatic test_frame_extremes();
        set_frame(11'd0, 11'd5);
        send_header();
        send_byte(8'ha0);
        send_color(16'h2345);
        set_frame(11'd2047, 11'd1);
        send_header();
        repeat (31) send_byte(8'h9f);
        send_byte(8'ha1);
        send_color(16'h5aa5);
        set_frame(11'd1024, 11'd1024);
        send_header();
        send_byte(8'h9f);
        send_byte(8'ha3);
        send_color(16'h7c1f);
        set_frame(11'd1, 11'd1024);
        send_header();
        send_byte(8'hbf);
        send_color(16'h03e0);
    endtask

    task automatic test_random_chunks();
        int ops;
        int pick;
        while (sent_bytes < 180) begin
            if ($urandom_range(0, 2) == 0)
                set_frame(11'($urandom_range(1, 6)), 11'($urandom_range(1, 6)));
            send_header();
            ops = $urandom_range(2, 10);
            for (int i = 0; i < ops; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    send_byte(8'ha0 | 8'($urandom_range(0, 31)));
                    send_color(16'($urandom));
                end else if (pick < 40) begin
                    send_byte(8'h80 | 8'($urandom_range(0, 31)));
                end else if (pick < 60) begin
                    send_quad($urandom_range(0, 2));
                end else if (pick < 72) begin
                    send_short_quad();
                end else if (pick < 78) begin
                    send_sixteen();
                end else if (pick < 82) begin
                    send_byte(8'he0 | 8'($urandom_range(0, 31)));
                end else if (pick < 92) begin
                    send_byte(8'($urandom));
                end else begin
                    send_byte(8'hc0 | 8'($urandom_range(0, 31)));
                    send_byte(8'($urandom));
                    break;
                end
            end
        end
    endtask

    // ---------------- receiver and checks ----------------
    int stall_mode = 0;
    int mode_cycles = 0;

    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(16, 96);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_block exp_b;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected beat: kind %0d col %0d row %0d", out_ch.kind,
                       out_ch.block_col, out_ch.block_row);
                errors++;
            end else begin
                exp_b = pending_blocks.pop_front();
                check_field("kind", exp_b.kind, out_ch.kind);
                check_field("block_col", exp_b.col, out_ch.block_col);
                check_field("block_row", exp_b.row, out_ch.block_row);
                check_field("pixels_row0", exp_b.r0, out_ch.pixels_row0);
                check_field("pixels_row1", exp_b.r1, out_ch.pixels_row1);
                check_field("pixels_row2", exp_b.r2, out_ch.pixels_row2);
                check_field("pixels_row3", exp_b.r3, out_ch.pixels_row3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_chunk();
        test_opcodes();
        test_sixteen_and_badop();
        test_frame_extremes();
        test_random_chunks();
        wait_idle();
        for (int i = 0; i < pending_blocks.size(); i++) begin
            $error("missing beat: kind %0d col %0d row %0d", pending_blocks[i].kind,
                   pending_blocks[i].col, pending_blocks[i].row);
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
